// File: rtl/core/oust_pkg.sv
// Shared constants and types for the ordered unique set table.
package oust_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned TOTAL_W = 7;

  typedef enum logic [1:0] {
    CMD_ADD_KEY  = 2'd0,
    CMD_ADD_PAIR = 2'd1,
    CMD_DEL_KEY  = 2'd2,
    CMD_GET_POS  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_READOK   = 3'd4,
    ST_RANGE    = 3'd5,
    ST_FULL     = 3'd6,
    ST_RSVD     = 3'd7
  } status_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] second;
  } entry_t;

endpackage

// File: rtl/core/oust_if.sv
// Request and response channel interfaces of the ordered unique set table.
interface oust_req_if import oust_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cmd_e                    cmd;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] second;
  logic [POS_W-1:0]        position;

  modport source (output valid, cmd, key, second, position, input ready);
  modport sink   (input valid, cmd, key, second, position, output ready);
endinterface

interface oust_rsp_if import oust_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_e                 status;
  logic signed [KEY_W-1:0] read_key;
  logic [TOTAL_W-1:0]      entry_total;

  modport source (output valid, status, read_key, entry_total, input ready);
  modport sink   (input valid, status, read_key, entry_total, output ready);
endinterface

// File: rtl/core/ordered_unique_set_table_unit.sv
// Ordered unique set table: sequencer, entry memory and response register.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------
//   req_i    | in  | valid / ready | cmd, key, second, position
//   rsp_o    | out | valid / ready | status, read_key, entry_total
//
// One item at a time; req_i.ready is high only while the sequencer is idle.
// Add and delete walk the entry memory one entry a cycle through its single
// read port: delete walks to the match and then shifts each later entry down
// (the walk and the shift together pass every entry once), add walks every
// entry unless a duplicate ends the walk early; get reads one entry, or skips
// the read when the position is at or past the count.
// The finished result waits in a staging register while rsp_o is stalled.
// Reset clears the entry count and control; memory contents need no reset.
module ordered_unique_set_table_unit
  import oust_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  oust_req_if.sink        req_i,
  oust_rsp_if.source      rsp_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  cmd_e                    cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] sec_q;
  status_e                 res_status_q, res_status_d;
  logic signed [KEY_W-1:0] res_key_q, res_key_d;

  logic                    rsp_vld_q;
  status_e                 rsp_status_q;
  logic signed [KEY_W-1:0] rsp_key_q;
  logic [TOTAL_W-1:0]      rsp_total_q;

  entry_t                  mem_q [DEPTH];
  entry_t                  rdata_q;
  entry_t                  wdata;
  logic                    mem_we;
  logic [IDX_W-1:0]        waddr;
  logic [IDX_W-1:0]        raddr;

  logic                    req_acc;
  logic                    rsp_load;
  logic                    match;
  logic [CNT_W-1:0]        nxt_idx;

  assign req_acc  = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == S_DONE) && (!rsp_vld_q || rsp_o.ready);
  assign match    = (rdata_q.key == key_q)
                    && ((cmd_q != CMD_ADD_PAIR) || (rdata_q.second == sec_q));
  assign nxt_idx  = idx_q + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    mem_we       = 1'b0;
    waddr        = cnt_q[IDX_W-1:0];
    wdata        = '{key: key_q, second: (cmd_q == CMD_ADD_KEY) ? '0 : sec_q};
    raddr        = '0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          idx_d     = '0;
          res_key_d = '0;
          if (req_i.cmd == CMD_GET_POS) begin
            if (32'(req_i.position) < 32'(cnt_q)) begin
              raddr   = IDX_W'(req_i.position);
              state_d = S_READ;
            end else begin
              res_status_d = ST_RANGE;
              state_d      = S_DONE;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q == cnt_q) begin
          // walked past the last entry without a hit
          state_d = S_DONE;
          if (cmd_q == CMD_DEL_KEY) begin
            res_status_d = ST_NOTFOUND;
          end else if (32'(cnt_q) == DEPTH) begin
            res_status_d = ST_FULL;
          end else begin
            mem_we       = 1'b1;
            cnt_d        = cnt_q + CNT_W'(1);
            res_status_d = ST_ADDED;
          end
        end else if (match) begin
          if (cmd_q == CMD_DEL_KEY) begin
            raddr   = IDX_W'(nxt_idx);
            state_d = S_SHIFT;
          end else begin
            res_status_d = ST_DUP;
            state_d      = S_DONE;
          end
        end else begin
          idx_d = nxt_idx;
          raddr = IDX_W'(nxt_idx);
        end
      end
      S_SHIFT: begin
        // rdata holds the entry after idx: move it down one place
        if (nxt_idx == cnt_q) begin
          cnt_d        = cnt_q - CNT_W'(1);
          res_status_d = ST_DELETED;
          state_d      = S_DONE;
        end else begin
          mem_we = 1'b1;
          waddr  = idx_q[IDX_W-1:0];
          wdata  = rdata_q;
          idx_d  = nxt_idx;
          raddr  = IDX_W'(nxt_idx + CNT_W'(1));
        end
      end
      S_READ: begin
        res_status_d = ST_READOK;
        res_key_d    = rdata_q.key;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key;
      sec_q <= req_i.second;
    end
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_key_q    <= res_key_q;
      rsp_total_q  <= TOTAL_W'(cnt_q);
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.read_key    = rsp_key_q;
  assign rsp_o.entry_total = rsp_total_q;

endmodule

// File: rtl/core/oust_checker.sv
// Port-level checks for the ordered unique set table, bound to the table unit.
module oust_checker
  import oust_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic [2:0]              rsp_status,
  input logic signed [KEY_W-1:0] rsp_read_key,
  input logic [TOTAL_W-1:0]      rsp_total
);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_read_key) && $stable(rsp_total))
    else $error("stalled response changed");

  // an accepted item keeps the sequencer busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request ready straight after accept");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status != ST_READOK) |-> rsp_read_key == '0)
    else $error("read key not zero outside read ok");

  a_added_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && ((rsp_status == ST_ADDED) || (rsp_status == ST_DUP)
      || (rsp_status == ST_READOK) || (rsp_status == ST_FULL))
      |-> rsp_total != '0)
    else $error("empty table after add, duplicate or read");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> 32'(rsp_total) <= DEPTH)
    else $error("entry total beyond depth");

endmodule

bind ordered_unique_set_table_unit oust_checker u_oust_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req_i.valid),
  .req_ready    (req_i.ready),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .rsp_status   (rsp_o.status),
  .rsp_read_key (rsp_o.read_key),
  .rsp_total    (rsp_o.entry_total)
);

// File: verif/testbench.sv
// Self-checking testbench for the ordered unique set table unit.
module testbench;
  import oust_pkg::*;

  localparam int ITEM_TOTAL  = 1150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    cmd_e                    cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] second;
    logic [POS_W-1:0]        position;
  } request_t;

  typedef struct {
    status_e                 status;
    logic signed [KEY_W-1:0] read_key;
    logic [TOTAL_W-1:0]      entry_total;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  oust_req_if req_if ();
  oust_rsp_if rsp_if ();

  ordered_unique_set_table_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Driven request and response-side signals
  logic     req_valid = 1'b0;
  request_t req_cur = '{cmd: CMD_ADD_KEY, key: '0, second: '0, position: '0};
  logic     rsp_take = 1'b0;

  assign req_if.valid    = req_valid;
  assign req_if.cmd      = req_cur.cmd;
  assign req_if.key      = req_cur.key;
  assign req_if.second   = req_cur.second;
  assign req_if.position = req_cur.position;
  assign rsp_if.ready    = rsp_take;

  request_t request_queue[$];
  result_t  pending_results[$];

  // Shadow copy of the table
  logic signed [KEY_W-1:0] table_key    [DEPTH];
  logic signed [KEY_W-1:0] table_second [DEPTH];
  int table_count = 0;
  int peak_count  = 0;
  int outcome_tally [8];

  logic [KEY_W-1:0] key_pool [128];

  int queued_total = 0;
  int sent_count   = 0;
  int rx_count     = 0;
  int fail_count   = 0;
  int cycle_count  = 0;
  int choke_left   = 0;

  function automatic void apply_to_table(input request_t rq);
    result_t res;
    int hit;
    hit = -1;
    res.status = ST_NOTFOUND;
    res.read_key = '0;
    case (rq.cmd)
      CMD_ADD_KEY, CMD_ADD_PAIR: begin
        for (int i = 0; i < table_count; i++)
          if (hit < 0 && table_key[i] == rq.key &&
              (rq.cmd == CMD_ADD_KEY || table_second[i] == rq.second)) hit = i;
        // duplicate wins over a full table
        if (hit >= 0) begin
          res.status = ST_DUP;
        end else if (table_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          table_key[table_count] = rq.key;
          table_second[table_count] = (rq.cmd == CMD_ADD_KEY) ? '0 : rq.second;
          table_count++;
          res.status = ST_ADDED;
        end
      end
      CMD_DEL_KEY: begin
        for (int i = 0; i < table_count; i++)
          if (hit < 0 && table_key[i] == rq.key) hit = i;
        if (hit >= 0) begin
          // close the gap so order is kept
          for (int i = hit; i + 1 < table_count; i++) begin
            table_key[i] = table_key[i + 1];
            table_second[i] = table_second[i + 1];
          end
          table_count--;
          res.status = ST_DELETED;
        end
      end
      default: begin
        if (int'(rq.position) < table_count) begin
          res.read_key = table_key[rq.position];
          res.status = ST_READOK;
        end else begin
          res.status = ST_RANGE;
        end
      end
    endcase
    res.entry_total = TOTAL_W'(table_count);
    if (table_count > peak_count) peak_count = table_count;
    outcome_tally[res.status]++;
    pending_results.push_back(res);
  endfunction

  function automatic void queue_op(input cmd_e c, input logic [KEY_W-1:0] k,
                                   input logic [KEY_W-1:0] s, input logic [POS_W-1:0] p);
    request_t rq;
    rq.cmd = c;
    rq.key = k;
    rq.second = s;
    rq.position = p;
    request_queue.push_back(rq);
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 45);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input int span);
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, span)];
    return $urandom();
  endfunction

  function automatic logic [KEY_W-1:0] pick_second();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 45) return 32'h8000_0000;
    if (r < 60) return 32'h7FFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 1) != 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(0, 15));
  endfunction

  // Driver: offer queued items, with random gaps between them
  bit       offering = 1'b0;
  request_t slot;
  int       idle_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (offering && req_if.ready) begin
        apply_to_table(slot);
        sent_count++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (request_queue.size() != 0) begin
          slot = request_queue.pop_front();
          offering = 1'b1;
          idle_left = pick_gap(((sent_count / 150) % 4) == 2);
        end
      end
      req_valid <= offering;
      req_cur <= slot;
    end
  end

  // Monitor: check each result against the oldest prediction
  int      stall_left = 0;
  bit      take;
  result_t got, want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_take) begin
        got.status = rsp_if.status;
        got.read_key = rsp_if.read_key;
        got.entry_total = rsp_if.entry_total;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, status %0d read_key %h total %0d",
                   $time, got.status, got.read_key, got.entry_total);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.read_key !== want.read_key ||
              got.entry_total !== want.entry_total) begin
            fail_count++;
            $display("%0t: result %0d: expected %0d %h %0d, got %0d %h %0d",
                     $time, rx_count, want.status, want.read_key, want.entry_total,
                     got.status, got.read_key, got.entry_total);
          end
        end
        rx_count++;
        stall_left = pick_gap(((rx_count / 150) % 4) == 1);
      end
      if (choke_left != 0) begin
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      rsp_take <= take;
    end
  end

  // Long receiver hold-offs so that the block backs up into its input
  int choke_clock = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      choke_clock <= choke_clock + 1;
      if (choke_left != 0) begin
        choke_left <= choke_left - 1;
      end else if (choke_clock == 6000 || choke_clock == 25000) begin
        choke_left <= 500;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int  n;
    int  kind;
    int  base;
    int  span;
    int  r;
    bit  first_fill;

    for (int i = 0; i < 128; i++) key_pool[i] = ($urandom() & 32'hFFFF_FF80) | 32'(i);
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[127] = 32'hFFFF_FFFF;

    // Directed: empty table, extremes, key-only and pair duplicates, shifts
    queue_op(CMD_GET_POS, '0, '0, 6'd0);
    queue_op(CMD_DEL_KEY, 32'h7FFF_FFFF, '0, 6'd0);
    queue_op(CMD_ADD_KEY, 32'h7FFF_FFFF, 32'h1234_5678, 6'd63);
    queue_op(CMD_ADD_KEY, 32'h8000_0000, 32'hFFFF_FFFF, 6'd0);
    queue_op(CMD_ADD_KEY, 32'h7FFF_FFFF, '0, 6'd0);
    queue_op(CMD_ADD_PAIR, 32'h7FFF_FFFF, '0, 6'd0);
    queue_op(CMD_ADD_PAIR, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0);
    queue_op(CMD_ADD_PAIR, '0, 32'h8000_0000, 6'd0);
    queue_op(CMD_ADD_PAIR, '0, 32'h8000_0000, 6'd0);
    queue_op(CMD_ADD_KEY, '0, 32'h7FFF_FFFF, 6'd0);
    queue_op(CMD_ADD_PAIR, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 6'd0);
    for (int i = 0; i < 5; i++) queue_op(CMD_GET_POS, '0, '0, POS_W'(i));
    queue_op(CMD_GET_POS, '0, '0, 6'd63);
    queue_op(CMD_DEL_KEY, 32'h7FFF_FFFF, '0, 6'd0);
    queue_op(CMD_GET_POS, '0, '0, 6'd1);
    queue_op(CMD_DEL_KEY, 32'h0001_2345, '0, 6'd0);
    queue_op(CMD_DEL_KEY, 32'h7FFF_FFFF, '0, 6'd0);
    queue_op(CMD_DEL_KEY, 32'hFFFF_FFFF, '0, 6'd0);
    queue_op(CMD_DEL_KEY, 32'h8000_0000, '0, 6'd0);
    queue_op(CMD_DEL_KEY, '0, '0, 6'd0);
    queue_op(CMD_GET_POS, '0, '0, 6'd0);

    base = 0;
    first_fill = 1'b1;
    while (request_queue.size() < ITEM_TOTAL) begin
      kind = first_fill ? 0 : $urandom_range(0, 9);
      first_fill = 1'b0;
      if (kind < 2) begin
        // distinct keys past capacity, then retry six of those keys
        base = $urandom_range(0, 127);
        n = $urandom_range(66, 80);
        for (int i = 0; i < n; i++)
          queue_op(($urandom_range(0, 1) != 0) ? CMD_ADD_KEY : CMD_ADD_PAIR,
                   key_pool[(base + i) % 128], pick_second(), pick_pos());
        for (int i = 0; i < 6; i++)
          queue_op(CMD_ADD_KEY, key_pool[(base + $urandom_range(0, n - 1)) % 128],
                   pick_second(), pick_pos());
      end else if (kind < 4) begin
        // drain the last filled window, with reads in between
        n = $urandom_range(40, 90);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0)
            queue_op(CMD_GET_POS, $urandom(), $urandom(), pick_pos());
          else
            queue_op(CMD_DEL_KEY, key_pool[(base + $urandom_range(0, 85)) % 128],
                     $urandom(), pick_pos());
        end
      end else if (kind < 9) begin
        r = $urandom_range(0, 2);
        span = (r == 0) ? 7 : (r == 1) ? 31 : 127;
        n = $urandom_range(30, 100);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 30)
            queue_op(CMD_ADD_KEY, pick_key(span), $urandom(), pick_pos());
          else if (r < 50)
            queue_op(CMD_ADD_PAIR, pick_key(span), pick_second(), pick_pos());
          else if (r < 75)
            queue_op(CMD_DEL_KEY, pick_key(span), $urandom(), pick_pos());
          else
            queue_op(CMD_GET_POS, $urandom(), $urandom(), pick_pos());
        end
      end else begin
        n = $urandom_range(10, 30);
        for (int i = 0; i < n; i++)
          queue_op(cmd_e'($urandom_range(0, 3)), $urandom(), $urandom(),
                   POS_W'($urandom_range(0, 63)));
      end
    end
    // drop the overshoot of the last burst
    while (request_queue.size() > ITEM_TOTAL) void'(request_queue.pop_back());
    queued_total = request_queue.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < queued_total) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results; peak occupancy %0d of %0d",
             sent_count, rx_count, peak_count, DEPTH);
    $display("Outcomes: add %0d, dup %0d, del %0d, miss %0d, read %0d, range %0d, full %0d",
             outcome_tally[ST_ADDED], outcome_tally[ST_DUP], outcome_tally[ST_DELETED],
             outcome_tally[ST_NOTFOUND], outcome_tally[ST_READOK], outcome_tally[ST_RANGE],
             outcome_tally[ST_FULL]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/oust_pkg.sv
rtl/core/oust_if.sv
rtl/core/ordered_unique_set_table_unit.sv
rtl/core/oust_checker.sv
verif/testbench.sv
